>>> rtl/core/bpr_pkg.sv
// Shared types, register indexes and mask setup for the bitfield pixel unpacker.
// Used by bpr_csr, bpr_chan_expand and bitfield_pixel_to_rgba8_unit.
package bpr_pkg;

   localparam int PIXEL_W = 32;
   localparam int CHAN_W  = 8;
   localparam int SHAMT_W = 5;
   localparam int INDEX_W = 8;
   localparam int TOP_BIT = 7;

   // Register indexes on the configuration port
   localparam logic [INDEX_W-1:0] CSR_RED_MASK   = 8'd0;
   localparam logic [INDEX_W-1:0] CSR_GREEN_MASK = 8'd1;
   localparam logic [INDEX_W-1:0] CSR_BLUE_MASK  = 8'd2;
   localparam logic [INDEX_W-1:0] CSR_ALPHA_MASK = 8'd3;

   localparam logic [PIXEL_W-1:0] RESET_RED_MASK   = 32'h00FF_0000;
   localparam logic [PIXEL_W-1:0] RESET_GREEN_MASK = 32'h0000_FF00;
   localparam logic [PIXEL_W-1:0] RESET_BLUE_MASK  = 32'h0000_00FF;
   localparam logic [PIXEL_W-1:0] RESET_ALPHA_MASK = 32'h0000_0000;

   localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'd255;

   // One channel's mask with the alignment and replication settings derived from it
   typedef struct packed {
      logic [PIXEL_W-1:0] mask;
      logic               zero;    // mask has no set bits
      logic               shr;     // 1: shift right, 0: shift left
      logic [SHAMT_W-1:0] amt;     // alignment shift amount
      logic [CHAN_W-1:0]  rep;     // rep[z] set: add (v >> z) into the sum
   } chan_cfg_type;

   typedef struct packed {
      chan_cfg_type red;
      chan_cfg_type green;
      chan_cfg_type blue;
      chan_cfg_type alpha;
   } pix_cfg_type;

   // Derive alignment and replication settings from a channel mask
   function automatic chan_cfg_type chan_setup(logic [PIXEL_W-1:0] m);
      chan_cfg_type       c;
      logic [SHAMT_W-1:0] hb;
      logic [5:0]         cnt;
      hb  = '0;
      for (int i = 0; i < PIXEL_W; i++) begin
         if (m[i]) hb = SHAMT_W'(i);
      end
      cnt    = 6'($countones(m));
      c.mask = m;
      c.zero = (m == '0);
      if (hb >= SHAMT_W'(TOP_BIT)) begin
         c.shr = 1'b1;
         c.amt = hb - SHAMT_W'(TOP_BIT);
      end else begin
         c.shr = 1'b0;
         c.amt = SHAMT_W'(TOP_BIT) - hb;
      end
      // shifts 0, cnt, 2*cnt, ... that stay below 8
      case (cnt)
         6'd1:    c.rep = 8'b1111_1111;
         6'd2:    c.rep = 8'b0101_0101;
         6'd3:    c.rep = 8'b0100_1001;
         6'd4:    c.rep = 8'b0001_0001;
         6'd5:    c.rep = 8'b0010_0001;
         6'd6:    c.rep = 8'b0100_0001;
         6'd7:    c.rep = 8'b1000_0001;
         default: c.rep = 8'b0000_0001;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/bpr_csr.sv
// Channel mask registers with their derived alignment and replication settings.
// Depends on bpr_pkg.
module bpr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [bpr_pkg::INDEX_W-1:0]   csr_index,
   input  logic [bpr_pkg::PIXEL_W-1:0]   csr_wdata,
   output bpr_pkg::pix_cfg_type          cfg
);
   import bpr_pkg::*;

   pix_cfg_type  cfg_ff;
   pix_cfg_type  cfg_in;
   chan_cfg_type setup;

   // Derive settings from the incoming word once, at write time
   assign setup = chan_setup(csr_wdata);

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RED_MASK:   cfg_in.red   = setup;
            CSR_GREEN_MASK: cfg_in.green = setup;
            CSR_BLUE_MASK:  cfg_in.blue  = setup;
            CSR_ALPHA_MASK: cfg_in.alpha = setup;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red   <= chan_setup(RESET_RED_MASK);
         cfg_ff.green <= chan_setup(RESET_GREEN_MASK);
         cfg_ff.blue  <= chan_setup(RESET_BLUE_MASK);
         cfg_ff.alpha <= chan_setup(RESET_ALPHA_MASK);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/bpr_chan_expand.sv
// Extracts one channel from a pixel word, aligns its top bit to bit 7 and
// replicates it downward to 8 bits. Depends on bpr_pkg.
module bpr_chan_expand (
   input  logic [bpr_pkg::PIXEL_W-1:0] pixel,
   input  bpr_pkg::chan_cfg_type       chan,
   output logic [bpr_pkg::CHAN_W-1:0]  value,
   output logic                        nonzero
);
   import bpr_pkg::*;

   logic [PIXEL_W-1:0] masked;
   logic [PIXEL_W-1:0] aligned;
   logic [CHAN_W-1:0]  v;
   logic [CHAN_W-1:0]  sum;

   // Mask and align
   assign masked  = pixel & chan.mask;
   assign aligned = chan.shr ? (masked >> chan.amt) : (masked << chan.amt);
   assign v       = aligned[CHAN_W-1:0];

   // Replicate: add the shifted copies the mask width calls for
   always_comb begin
      sum = '0;
      for (int z = 0; z < CHAN_W; z++) begin
         if (chan.rep[z]) sum = sum + (v >> z);
      end
   end

   assign value   = sum;
   // The full sum is at least v, so it is nonzero exactly when v is
   assign nonzero = (v != '0);

endmodule

>>> rtl/core/bitfield_pixel_to_rgba8_unit.sv
// Top level of the bitfield pixel to RGBA8 unpacker: input stage, channel
// expanders, result stage and alpha-seen flag. Depends on bpr_pkg, bpr_csr, bpr_chan_expand.
//
//   channel  handshake           payload
//   req      req_valid/ready     req_pixel_word[31:0], req_first_of_image
//   rsp      rsp_valid/ready     rsp_red/green/blue/alpha_out[7:0], rsp_alpha_seen
//   csr      csr_write_en        csr_index[7:0], csr_wdata[31:0]
//
// One word per cycle while the result port is not stalled; a word passes the
// input register, then the result register, before it is on the result port.
// Synchronous active-high reset empties both stages, clears the alpha-seen
// flag and loads the default masks.
// A stalled result holds its register; the input stage still takes a word
// while it is empty, so one word can wait behind the result.
module bitfield_pixel_to_rgba8_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bpr_pkg::PIXEL_W-1:0]   req_pixel_word,
   input  logic                          req_first_of_image,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bpr_pkg::CHAN_W-1:0]    rsp_red_out,
   output logic [bpr_pkg::CHAN_W-1:0]    rsp_green_out,
   output logic [bpr_pkg::CHAN_W-1:0]    rsp_blue_out,
   output logic [bpr_pkg::CHAN_W-1:0]    rsp_alpha_out,
   output logic                          rsp_alpha_seen,
   input  logic                          csr_write_en,
   input  logic [bpr_pkg::INDEX_W-1:0]   csr_index,
   input  logic [bpr_pkg::PIXEL_W-1:0]   csr_wdata
);
   import bpr_pkg::*;

   pix_cfg_type        cfg;

   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] in_pixel_ff;
   logic               in_first_ff;
   logic               in_ready;

   logic               out_valid_ff, out_valid_in;
   logic [CHAN_W-1:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic               seen_ff;
   logic               flag_ff, flag_in;
   logic               advance;
   logic               out_ready;

   logic [CHAN_W-1:0]  red_v, green_v, blue_v, alpha_v;
   logic               red_nz, green_nz, blue_nz, alpha_nz;
   logic [CHAN_W-1:0]  alpha_sel;
   logic               alpha_sel_nz;
   logic               unused_nz;

   bpr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bpr_chan_expand u_red (
      .pixel (in_pixel_ff), .chan (cfg.red),   .value (red_v),   .nonzero (red_nz)
   );
   bpr_chan_expand u_green (
      .pixel (in_pixel_ff), .chan (cfg.green), .value (green_v), .nonzero (green_nz)
   );
   bpr_chan_expand u_blue (
      .pixel (in_pixel_ff), .chan (cfg.blue),  .value (blue_v),  .nonzero (blue_nz)
   );
   bpr_chan_expand u_alpha (
      .pixel (in_pixel_ff), .chan (cfg.alpha), .value (alpha_v), .nonzero (alpha_nz)
   );

   // Handshakes: each stage frees when its word moves on
   assign out_ready   = !out_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && out_ready;
   assign in_ready    = !in_valid_ff || out_ready;
   assign req_ready   = in_ready;
   assign in_valid_in = (req_valid && in_ready) || (in_valid_ff && !out_ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Zero alpha mask means opaque
   assign alpha_sel    = cfg.alpha.zero ? OPAQUE_ALPHA : alpha_v;
   assign alpha_sel_nz = cfg.alpha.zero || alpha_nz;

   // Clear the flag on a new image, then set on nonzero alpha
   assign flag_in = (in_first_ff ? 1'b0 : flag_ff) | alpha_sel_nz;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) flag_ff <= flag_in;
      end
   end

   // Input stage: load a word on accept
   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_pixel_ff <= req_pixel_word;
         in_first_ff <= req_first_of_image;
      end
   end

   // Result stage: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_v;
         green_ff <= green_v;
         blue_ff  <= blue_v;
         alpha_ff <= alpha_sel;
         seen_ff  <= flag_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red_out    = red_ff;
   assign rsp_green_out  = green_ff;
   assign rsp_blue_out   = blue_ff;
   assign rsp_alpha_out  = alpha_ff;
   assign rsp_alpha_seen = seen_ff;

   // Color channel nonzero flags are not needed downstream
   assign unused_nz = red_nz ^ green_nz ^ blue_nz;

endmodule
